[src/pdg_pkg.sv]
// shared types, codes and step functions of the pair distance gather block
`default_nettype none
package pdg_pkg;

	localparam int MAX_POINTS = 256;
	localparam int PERM_DEPTH = 1024;
	localparam int DIST_DEPTH = (MAX_POINTS * (MAX_POINTS + 1)) / 2;
	localparam int NB_AW      = $clog2(MAX_POINTS);
	localparam int PERM_AW    = $clog2(PERM_DEPTH);
	localparam int DIST_AW    = $clog2(DIST_DEPTH);

	// remainder pipeline for the group modulo: 18 dividend bits, two per stage
	localparam int MOD_STAGES  = 9;
	// grid fold: four stages of modulo by the subset size, four of divide by the width
	localparam int FOLD_HALF   = 4;
	localparam int FOLD_STAGES = 2 * FOLD_HALF;

	typedef enum logic [1:0] {
		ACT_NB_WR   = 2'd0,
		ACT_PERM_WR = 2'd1,
		ACT_DIST_WR = 2'd2,
		ACT_FETCH   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_GROUP_COUNT    = 3'd0,
		REG_PERMUTE_ENABLE = 3'd1,
		REG_ITEM_COUNT     = 3'd2,
		REG_REF_ITEM_COUNT = 3'd3,
		REG_SUB_WIDTH      = 3'd4,
		REG_REF_WIDTH      = 3'd5,
		REG_ROW_PITCH      = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] num;
		logic [9:0] rem;
		logic [7:0] quo;
	} lane_t;

	typedef struct packed {
		logic        vld;
		action_t     act;
		logic [15:0] idx;
		logic [31:0] val;
		logic [9:0]  elem;
		logic [7:0]  iter;
		logic [16:0] bsum;
		logic        err;
		logic [17:0] page;
		logic [17:0] num;
		logic [9:0]  rem;
		logic [7:0]  j;
		lane_t       li;
		lane_t       lj;
		logic [18:0] pq_i;
		logic [18:0] pq_j;
		logic [7:0]  col;
		logic [16:0] rprod;
	} item_t;

	// one restoring step: returns {quotient bit, new remainder}
	function automatic logic [10:0] div_step(logic [9:0] r, logic b, logic [8:0] d);
		logic [9:0] sh;
		sh = {r[8:0], b};
		if (sh >= {1'b0, d})
			return {1'b1, sh - {1'b0, d}};
		else
			return {1'b0, sh};
	endfunction

	function automatic lane_t lane_step2(lane_t l, logic [8:0] d);
		logic [10:0] t;
		lane_t       x;
		x = l;
		for (int s = 0; s < 2; s++) begin
			t = div_step(x.rem, x.num[7], d);
			x.rem = t[9:0];
			x.num = {x.num[6:0], 1'b0};
			x.quo = {x.quo[6:0], t[10]};
		end
		return x;
	endfunction

endpackage
`default_nettype wire

[src/pair_distance_gather_top.sv]
// Pair distance gather: a fully pipelined gather that takes one beat per cycle while the
// output is not stalled and returns one result beat per fetch. Every beat, writes included,
// walks the same stages in order, and each table is written at the stage where it is read
// (the neighbour table and the permutation table are kept in two copies for their two read
// points), so no forwarding is needed. Most of the pipeline depth comes from the group-count
// remainder pipeline (nine stages, two bits each) and the grid fold pipeline (eight
// stages), both running at two divider steps per stage. A stalled output freezes the
// whole pipeline; the stores are not cleared at reset.
`default_nettype none
module pair_distance_gather_top import pdg_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// index[15:0], value[47:16], element[57:48], iter_base[73:58], iteration[81:74]
	input  wire  [87:0] s_tdata,
	// action[1:0]
	input  wire  [1:0]  s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// distance[31:0], page_index[49:32]
	output logic [55:0] m_tdata,
	// index_error[0]
	output logic [0:0]  m_tuser,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [10:0] cfg_data
);

	logic [6:0]  group_count_q;
	logic        permute_q;
	logic [8:0]  item_count_q;
	logic [8:0]  ref_item_count_q;
	logic [8:0]  sub_width_q;
	logic [8:0]  ref_width_q;
	logic [10:0] row_pitch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_count_q    <= 7'd64;
			permute_q        <= 1'b0;
			item_count_q     <= 9'd256;
			ref_item_count_q <= 9'd256;
			sub_width_q      <= 9'd16;
			ref_width_q      <= 9'd16;
			row_pitch_q      <= 11'd32;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GROUP_COUNT:    group_count_q    <= cfg_data[6:0];
				REG_PERMUTE_ENABLE: permute_q        <= cfg_data[0];
				REG_ITEM_COUNT:     item_count_q     <= cfg_data[8:0];
				REG_REF_ITEM_COUNT: ref_item_count_q <= cfg_data[8:0];
				REG_SUB_WIDTH:      sub_width_q      <= cfg_data[8:0];
				REG_REF_WIDTH:      ref_width_q      <= cfg_data[8:0];
				REG_ROW_PITCH:      row_pitch_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	logic        en;
	logic        out_vld_q;
	logic [31:0] out_dist_q;
	logic [17:0] out_page_q;
	logic        out_err_q;

	// whole pipeline advances unless the output beat is held
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	item_t s0, m0, p2_in, f0, p3_in, p4_in, p5_in, p6_in;
	item_t p1_s1, p2_s2, p3_s3, p4_s4, p5_s5, p6_s6;
	item_t md [MOD_STAGES+1];
	item_t md_nx [MOD_STAGES];
	item_t fl [FOLD_STAGES+1];
	item_t fl_nx [FOLD_STAGES];

	logic [7:0]  nb_a_rd, nb_b_rd, perm_i_rd, perm_j_rd;
	logic [31:0] dist_rd;
	logic [14:0] ig;
	logic [16:0] nsum;
	logic [8:0]  slot;
	logic [19:0] gi, gj;
	logic [7:0]  iv, jv;
	logic [15:0] didx;

	always_comb begin
		s0       = '0;
		s0.vld   = s_tvalid;
		s0.act   = action_t'(s_tuser);
		s0.idx   = s_tdata[15:0];
		s0.val   = s_tdata[47:16];
		s0.elem  = s_tdata[57:48];
		s0.iter  = s_tdata[81:74];
		s0.bsum  = {1'b0, s_tdata[73:58]} + {9'd0, s_tdata[81:74]};
	end

	pdg_ram #(.WIDTH(8), .DEPTH(MAX_POINTS)) u_nb_a (
		.clk(clk),
		.we(en && s_tvalid && s0.act == ACT_NB_WR && {1'b0, s0.idx} < 17'(MAX_POINTS)),
		.waddr(s0.idx[NB_AW-1:0]), .wdata(s0.val[7:0]),
		.re(en), .raddr(s0.elem[9:2]), .rdata(nb_a_rd)
	);

	// neighbour value plus offsets, then into the remainder pipeline
	always_comb begin
		m0      = p1_s1;
		nsum    = {9'd0, nb_a_rd} + p1_s1.bsum;
		ig      = {7'd0, p1_s1.iter} * {8'd0, group_count_q};
		m0.num  = {1'b0, nsum};
		m0.rem  = '0;
		m0.err  = (group_count_q == 7'd0);
		m0.page = 18'(p1_s1.elem) + {ig[13:0], 4'b0000};
	end

	always_comb begin
		logic [10:0] t;
		for (int k = 0; k < MOD_STAGES; k++) begin
			md_nx[k] = md[k];
			for (int s = 0; s < 2; s++) begin
				t = div_step(md_nx[k].rem, md_nx[k].num[17], {2'b00, group_count_q});
				md_nx[k].rem = t[9:0];
				md_nx[k].num = {md_nx[k].num[16:0], 1'b0};
			end
		end
	end

	always_comb begin
		p2_in = md[MOD_STAGES];
		slot  = {md[MOD_STAGES].rem[6:0], md[MOD_STAGES].elem[1:0]};
		if ({7'd0, slot} >= 16'(MAX_POINTS))
			p2_in.err = 1'b1;
	end

	pdg_ram #(.WIDTH(8), .DEPTH(MAX_POINTS)) u_nb_b (
		.clk(clk),
		.we(en && p2_in.vld && p2_in.act == ACT_NB_WR && {1'b0, p2_in.idx} < 17'(MAX_POINTS)),
		.waddr(p2_in.idx[NB_AW-1:0]), .wdata(p2_in.val[7:0]),
		.re(en), .raddr(slot[NB_AW-1:0]), .rdata(nb_b_rd)
	);

	// partner known: start both grid folds
	always_comb begin
		f0    = p2_s2;
		f0.j  = nb_b_rd;
		f0.li = '{num: p2_s2.elem[9:2], rem: '0, quo: '0};
		f0.lj = '{num: nb_b_rd, rem: '0, quo: '0};
		if (permute_q && (item_count_q == 9'd0 || ref_item_count_q == 9'd0 ||
				sub_width_q == 9'd0 || ref_width_q == 9'd0))
			f0.err = 1'b1;
	end

	always_comb begin
		for (int k = 0; k < FOLD_STAGES; k++) begin
			fl_nx[k] = fl[k];
			if (k < FOLD_HALF) begin
				fl_nx[k].li = lane_step2(fl[k].li, item_count_q);
				fl_nx[k].lj = lane_step2(fl[k].lj, ref_item_count_q);
			end else begin
				fl_nx[k].li = lane_step2(fl[k].li, sub_width_q);
				fl_nx[k].lj = lane_step2(fl[k].lj, ref_width_q);
			end
			// subset remainder becomes the dividend of the width division
			if (k == FOLD_HALF - 1) begin
				fl_nx[k].li = '{num: fl_nx[k].li.rem[7:0], rem: '0, quo: '0};
				fl_nx[k].lj = '{num: fl_nx[k].lj.rem[7:0], rem: '0, quo: '0};
			end
		end
	end

	always_comb begin
		p3_in      = fl[FOLD_STAGES];
		p3_in.pq_i = {11'd0, fl[FOLD_STAGES].li.quo} * {8'd0, row_pitch_q};
		p3_in.pq_j = {11'd0, fl[FOLD_STAGES].lj.quo} * {8'd0, row_pitch_q};
	end

	always_comb begin
		p4_in = p3_s3;
		gi    = {1'b0, p3_s3.pq_i} + {11'd0, p3_s3.li.rem[8:0]};
		gj    = {1'b0, p3_s3.pq_j} + {11'd0, p3_s3.lj.rem[8:0]};
		if (permute_q && (gi >= 20'(PERM_DEPTH) || gj >= 20'(PERM_DEPTH)))
			p4_in.err = 1'b1;
	end

	pdg_ram #(.WIDTH(8), .DEPTH(PERM_DEPTH)) u_perm_i (
		.clk(clk),
		.we(en && p3_s3.vld && p3_s3.act == ACT_PERM_WR &&
			{1'b0, p3_s3.idx} < 17'(PERM_DEPTH)),
		.waddr(p3_s3.idx[PERM_AW-1:0]), .wdata(p3_s3.val[7:0]),
		.re(en), .raddr(gi[PERM_AW-1:0]), .rdata(perm_i_rd)
	);

	pdg_ram #(.WIDTH(8), .DEPTH(PERM_DEPTH)) u_perm_j (
		.clk(clk),
		.we(en && p3_s3.vld && p3_s3.act == ACT_PERM_WR &&
			{1'b0, p3_s3.idx} < 17'(PERM_DEPTH)),
		.waddr(p3_s3.idx[PERM_AW-1:0]), .wdata(p3_s3.val[7:0]),
		.re(en), .raddr(gj[PERM_AW-1:0]), .rdata(perm_j_rd)
	);

	// row is the larger index; row*(row+1) is halved later to give the triangle base
	always_comb begin
		logic [7:0] row;
		p5_in = p4_s4;
		iv    = permute_q ? perm_i_rd : p4_s4.elem[9:2];
		jv    = permute_q ? perm_j_rd : p4_s4.j;
		row   = (iv > jv) ? iv : jv;
		p5_in.col   = (iv > jv) ? jv : iv;
		p5_in.rprod = {9'd0, row} * ({9'd0, row} + 17'd1);
	end

	always_comb begin
		p6_in = p5_s5;
		didx  = p5_s5.rprod[16:1] + {8'd0, p5_s5.col};
	end

	pdg_ram #(.WIDTH(32), .DEPTH(DIST_DEPTH)) u_dist (
		.clk(clk),
		.we(en && p5_s5.vld && p5_s5.act == ACT_DIST_WR &&
			{1'b0, p5_s5.idx} < 17'(DIST_DEPTH)),
		.waddr(p5_s5.idx[DIST_AW-1:0]), .wdata(p5_s5.val),
		.re(en), .raddr(didx[DIST_AW-1:0]), .rdata(dist_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_s1.vld <= 1'b0;
			p2_s2.vld <= 1'b0;
			p3_s3.vld <= 1'b0;
			p4_s4.vld <= 1'b0;
			p5_s5.vld <= 1'b0;
			p6_s6.vld <= 1'b0;
			for (int k = 0; k <= MOD_STAGES; k++)
				md[k].vld <= 1'b0;
			for (int k = 0; k <= FOLD_STAGES; k++)
				fl[k].vld <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			p1_s1 <= s0;
			md[0] <= m0;
			for (int k = 0; k < MOD_STAGES; k++)
				md[k+1] <= md_nx[k];
			p2_s2 <= p2_in;
			fl[0] <= f0;
			for (int k = 0; k < FOLD_STAGES; k++)
				fl[k+1] <= fl_nx[k];
			p3_s3 <= p3_in;
			p4_s4 <= p4_in;
			p5_s5 <= p5_in;
			p6_s6 <= p6_in;
			out_vld_q  <= p6_s6.vld && p6_s6.act == ACT_FETCH;
			out_dist_q <= p6_s6.err ? 32'd0 : dist_rd;
			out_page_q <= p6_s6.page;
			out_err_q  <= p6_s6.err;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'd0, out_page_q, out_dist_q};
	assign m_tuser  = out_err_q;

`ifndef SYNTH
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'd0)
		else $error("index error beat carries nonzero distance");

	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		md[MOD_STAGES].vld && md[MOD_STAGES].act == ACT_FETCH &&
		group_count_q != 7'd0 |->
		md[MOD_STAGES].rem < {3'd0, group_count_q})
		else $error("group remainder not below group count");

	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		fl[FOLD_STAGES].vld && !fl[FOLD_STAGES].err && permute_q |->
		fl[FOLD_STAGES].li.rem < {1'b0, sub_width_q})
		else $error("grid column not below subset width");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(p6_s6.vld) && $stable(md[0].vld))
		else $error("pipeline moved while output stalled");
`endif

endmodule
`default_nettype wire

[src/pdg_ram.sv]
// simple dual-port ram with registered read
`default_nettype none
module pdg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
